[sv/ptre_pkg.sv]
// ----------------------------------------------------------------------------
// ptre_pkg
// Shared widths, command codes, handshake structs and small helpers of the
// print time remaining estimator.
// ----------------------------------------------------------------------------
package ptre_pkg;

	localparam int FUNC_W = 2;
	localparam int PCT_W  = 7;
	localparam int SEC_W  = 32;
	localparam int TEMP_W = 9;
	localparam int WAIT_W = 8;
	localparam int BAR_W  = 4;
	localparam int HR_W   = 16;
	localparam int MIN_W  = 6;

	localparam int DIV_W    = 40;
	localparam int DIVR_W   = 7;
	localparam int DIV_STEP = 4;
	localparam int DIV_CYC  = DIV_W / DIV_STEP;
	localparam int DCNT_W   = $clog2(DIV_CYC);
	localparam int WSEC_W   = WAIT_W + 6;
	localparam int PROD_W   = SEC_W + PCT_W;

	localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_START  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

	localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;
	localparam logic [PCT_W-1:0]  PCT_HALF    = 7'd50;
	localparam logic [DIVR_W-1:0] SEC_PER_MIN = 7'd60;
	localparam logic [DIVR_W-1:0] DIVR_ONE    = 7'd1;
	localparam logic [WAIT_W-1:0] WAIT_RESET  = 8'd1;
	localparam logic [BAR_W-1:0]  BAR_FULL    = 4'd10;
	localparam logic [HR_W-1:0]   HOURS_MAX   = 16'hffff;

	typedef struct packed {
		logic              changed;
		logic [PCT_W-1:0]  shown;
		logic              tvalid;
		logic              split;
		logic              known;
		logic [SEC_W-1:0]  elapsed;
		logic [SEC_W-1:0]  span;
		logic [PCT_W-1:0]  factor;
		logic [PCT_W-1:0]  gain;
	} job_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quot;
		logic [DIVR_W-1:0] rem;
	} div_rsp_t;

	// floor(v/5) for v up to 50, as (v*13)>>6
	function automatic logic [BAR_W-1:0] fifth(input logic [PCT_W-1:0] v);
		logic [PCT_W+3:0] p;
		p = (PCT_W+4)'(v) * (PCT_W+4)'(13);
		return p[BAR_W+5:6];
	endfunction

	function automatic logic [BAR_W-1:0] bar_first(input logic [PCT_W-1:0] v);
		return (v <= PCT_HALF) ? fifth(v) : BAR_FULL;
	endfunction

	function automatic logic [BAR_W-1:0] bar_second(input logic [PCT_W-1:0] v);
		return (v > PCT_HALF) ? fifth(v - PCT_HALF) : '0;
	endfunction

	function automatic logic [HR_W-1:0] sat_hours(input logic [DIV_W-1:0] q);
		return (|q[DIV_W-1:HR_W]) ? HOURS_MAX : q[HR_W-1:0];
	endfunction

endpackage

[sv/ptre_ifs.sv]
// ----------------------------------------------------------------------------
// ptre channel interfaces
// Valid/ready channels for update items, result items and the wait register.
// ----------------------------------------------------------------------------
interface ptre_req_if import ptre_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [PCT_W-1:0]  percent_done;
	logic [SEC_W-1:0]  elapsed_seconds;
	logic [TEMP_W-1:0] heater_temp;
	logic [TEMP_W-1:0] heater_target;
	logic              refresh_times;

	modport source (output valid, func, percent_done, elapsed_seconds, heater_temp,
		heater_target, refresh_times, input ready);
	modport sink (input valid, func, percent_done, elapsed_seconds, heater_temp,
		heater_target, refresh_times, output ready);
endinterface

interface ptre_rsp_if import ptre_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              progress_changed;
	logic [PCT_W-1:0]  percent_shown;
	logic [BAR_W-1:0]  bar_first_half;
	logic [BAR_W-1:0]  bar_second_half;
	logic              times_valid;
	logic [HR_W-1:0]   elapsed_hours;
	logic [MIN_W-1:0]  elapsed_minutes;
	logic              remaining_known;
	logic [HR_W-1:0]   remaining_hours;
	logic [MIN_W-1:0]  remaining_minutes;

	modport source (output valid, progress_changed, percent_shown, bar_first_half,
		bar_second_half, times_valid, elapsed_hours, elapsed_minutes, remaining_known,
		remaining_hours, remaining_minutes, input ready);
	modport sink (input valid, progress_changed, percent_shown, bar_first_half,
		bar_second_half, times_valid, elapsed_hours, elapsed_minutes, remaining_known,
		remaining_hours, remaining_minutes, output ready);
endinterface

interface ptre_cfg_if import ptre_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WAIT_W-1:0] wait_minutes;

	modport source (output valid, wait_minutes, input ready);
	modport sink (input valid, wait_minutes, output ready);
endinterface

[sv/ptre_div.sv]
// ----------------------------------------------------------------------------
// ptre_div
// Shared restoring divider, 40-bit dividend by 7-bit divisor, four quotient
// bits per cycle.
// ----------------------------------------------------------------------------
module ptre_div import ptre_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0]  acc_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] div_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIV_W-1:0]  acc_nx;
	logic [DIVR_W-1:0] rem_nx;
	logic [DIVR_W:0]   trial;

	always_comb begin
		acc_nx = acc_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			trial  = {rem_nx, acc_nx[DIV_W-1]};
			acc_nx = {acc_nx[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_nx    = DIVR_W'(trial - {1'b0, div_q});
				acc_nx[0] = 1'b1;
			end else begin
				rem_nx = trial[DIVR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			rem_q  <= '0;
			div_q  <= DIVR_ONE;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			acc_q  <= req.dividend;
			rem_q  <= '0;
			div_q  <= req.divisor;
			cnt_q  <= DCNT_W'(DIV_CYC - 1);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			acc_q  <= acc_nx;
			rem_q  <= rem_nx;
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != '0);
			done_q <= (cnt_q == '0);
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = acc_q;
	assign rsp.rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < div_q)
		else $error("divider remainder not below divisor");

endmodule

[sv/ptre_track.sv]
// ----------------------------------------------------------------------------
// ptre_track
// Job phase tracking, baseline capture and wait register; turns an accepted
// item into the work for the sequencer.
// ----------------------------------------------------------------------------
module ptre_track import ptre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [FUNC_W-1:0] func,
	input  logic [PCT_W-1:0]  percent_done,
	input  logic [SEC_W-1:0]  elapsed_seconds,
	input  logic [TEMP_W-1:0] heater_temp,
	input  logic [TEMP_W-1:0] heater_target,
	input  logic              refresh_times,
	input  logic              cfg_we,
	input  logic [WAIT_W-1:0] cfg_wait,
	output job_t              job
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEATING,
		PH_WAITING,
		PH_ESTIMATING
	} phase_t;

	phase_t            phase_q;
	logic [PCT_W-1:0]  last_pct_q;
	logic [SEC_W-1:0]  base_sec_q;
	logic [PCT_W-1:0]  base_pct_q;
	logic [WAIT_W-1:0] wait_q;

	logic [PCT_W-1:0]  pct;
	logic              is_upd;
	logic [SEC_W-1:0]  since;
	logic [WSEC_W-1:0] wait_sec;

	always_comb begin
		pct      = (percent_done > PCT_FULL) ? PCT_FULL : percent_done;
		is_upd   = (func == FUNC_UPDATE);
		since    = elapsed_seconds - base_sec_q;
		wait_sec = WSEC_W'(wait_q) * WSEC_W'(SEC_PER_MIN);

		job.changed = is_upd && (pct != last_pct_q);
		job.shown   = is_upd ? pct : last_pct_q;
		job.tvalid  = (func == FUNC_START) || (is_upd && refresh_times);
		job.split   = is_upd && refresh_times;
		job.known   = is_upd && refresh_times && (phase_q == PH_ESTIMATING);
		job.elapsed = elapsed_seconds;
		job.span    = (elapsed_seconds > base_sec_q) ? since : '0;
		job.gain    = (pct > base_pct_q) ? (pct - base_pct_q) : '0;
		job.factor  = (job.gain == '0) ? '0 : (PCT_FULL - job.gain);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			last_pct_q <= '0;
			base_sec_q <= '0;
			base_pct_q <= '0;
			wait_q     <= WAIT_RESET;
		end else begin
			if (cfg_we) begin
				wait_q <= cfg_wait;
			end
			if (accept) begin
				unique case (func)
					FUNC_START: begin
						phase_q <= PH_HEATING;
					end
					FUNC_FINISH: begin
						phase_q <= PH_IDLE;
					end
					FUNC_UPDATE: begin
						last_pct_q <= pct;
						if (refresh_times) begin
							unique case (phase_q)
								PH_HEATING: begin
									if (heater_temp >= heater_target) begin
										phase_q    <= PH_WAITING;
										base_sec_q <= elapsed_seconds;
										base_pct_q <= pct;
									end
								end
								PH_WAITING: begin
									if (since >= SEC_W'(wait_sec)) begin
										phase_q <= PH_ESTIMATING;
									end
								end
								default: begin
								end
							endcase
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

[sv/ptre_seq.sv]
// ----------------------------------------------------------------------------
// ptre_seq
// Sequencer around the shared divider: hour/minute splits, the remaining
// time extrapolation, and the result register.
// ----------------------------------------------------------------------------
module ptre_seq import ptre_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  job_t          job,
	output logic          ready,
	ptre_rsp_if.source    rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_EMIN,
		OP_EHR,
		OP_REM,
		OP_RMIN,
		OP_RHR
	} op_t;

	state_t           state_q;
	op_t              op_q;
	job_t             job_q;
	div_req_t         dreq_q;
	div_rsp_t         drsp;
	logic [HR_W-1:0]  eh_q;
	logic [MIN_W-1:0] em_q;
	logic [HR_W-1:0]  rh_q;
	logic [MIN_W-1:0] rm_q;
	logic [PROD_W-1:0] prod;

	function automatic div_req_t mk_req(input logic [DIV_W-1:0] a,
		input logic [DIVR_W-1:0] b);
		div_req_t r;
		r.start    = 1'b1;
		r.dividend = a;
		r.divisor  = b;
		return r;
	endfunction

	ptre_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq_q),
		.rsp    (drsp)
	);

	assign ready = (state_q == S_IDLE);
	assign prod  = PROD_W'(job_q.span) * PROD_W'(job_q.factor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q               <= S_IDLE;
			op_q                  <= OP_EMIN;
			job_q                 <= '0;
			dreq_q                <= '0;
			eh_q                  <= '0;
			em_q                  <= '0;
			rh_q                  <= '0;
			rm_q                  <= '0;
			rsp.valid             <= 1'b0;
			rsp.progress_changed  <= 1'b0;
			rsp.percent_shown     <= '0;
			rsp.bar_first_half    <= '0;
			rsp.bar_second_half   <= '0;
			rsp.times_valid       <= 1'b0;
			rsp.elapsed_hours     <= '0;
			rsp.elapsed_minutes   <= '0;
			rsp.remaining_known   <= 1'b0;
			rsp.remaining_hours   <= '0;
			rsp.remaining_minutes <= '0;
		end else begin
			// start pulse lasts one cycle, no new request can follow it directly
			if (dreq_q.start) begin
				dreq_q.start <= 1'b0;
			end
			if (rsp.ready && state_q != S_DONE) begin
				rsp.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						job_q <= job;
						eh_q  <= '0;
						em_q  <= '0;
						rh_q  <= '0;
						rm_q  <= '0;
						if (job.split) begin
							op_q    <= OP_EMIN;
							dreq_q  <= mk_req(DIV_W'(job.elapsed), SEC_PER_MIN);
							state_q <= S_DIV;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DIV: begin
					if (drsp.done) begin
						unique case (op_q)
							OP_EMIN: begin
								op_q   <= OP_EHR;
								dreq_q <= mk_req(drsp.quot, SEC_PER_MIN);
							end
							OP_EHR: begin
								eh_q    <= sat_hours(drsp.quot);
								em_q    <= MIN_W'(drsp.rem);
								state_q <= job_q.known ? S_MUL : S_DONE;
							end
							OP_REM: begin
								op_q   <= OP_RMIN;
								dreq_q <= mk_req(drsp.quot, SEC_PER_MIN);
							end
							OP_RMIN: begin
								op_q   <= OP_RHR;
								dreq_q <= mk_req(drsp.quot, SEC_PER_MIN);
							end
							OP_RHR: begin
								rh_q    <= sat_hours(drsp.quot);
								rm_q    <= MIN_W'(drsp.rem);
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_MUL: begin
					op_q    <= OP_REM;
					dreq_q  <= mk_req(DIV_W'(prod),
						(job_q.gain == '0) ? DIVR_ONE : job_q.gain);
					state_q <= S_DIV;
				end
				S_DONE: begin
					if (!rsp.valid || rsp.ready) begin
						rsp.valid             <= 1'b1;
						rsp.progress_changed  <= job_q.changed;
						rsp.percent_shown     <= job_q.shown;
						rsp.bar_first_half    <= bar_first(job_q.shown);
						rsp.bar_second_half   <= bar_second(job_q.shown);
						rsp.times_valid       <= job_q.tvalid;
						rsp.elapsed_hours     <= eh_q;
						rsp.elapsed_minutes   <= em_q;
						rsp.remaining_known   <= job_q.known;
						rsp.remaining_hours   <= rh_q;
						rsp.remaining_minutes <= rm_q;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("sequencer idle right after an accepted item");

	a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == S_DIV)
		else $error("divider finished outside a divide step");

	a_no_times_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.times_valid |-> rsp.elapsed_hours == '0 &&
		rsp.elapsed_minutes == '0 && !rsp.remaining_known)
		else $error("time fields set without times_valid");

	a_no_estimate_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.remaining_known |-> rsp.remaining_hours == '0 &&
		rsp.remaining_minutes == '0)
		else $error("remaining fields set without an estimate");

endmodule

[sv/print_time_remaining_estimator.sv]
// ----------------------------------------------------------------------------
// print_time_remaining_estimator
// Tracks a job's phase and estimates its remaining time in hours and minutes.
//
// req carries one command item (update, start or finish); rsp returns exactly
// one result item per command; cfg writes the wait time in minutes and is
// always ready. The user must write cfg only while no item is in flight;
// the block itself does not enforce this. An item is taken only while the
// sequencer is idle. Its work runs on one shared divider (four quotient
// bits per cycle). Start, finish or an update without refresh needs no
// divide; an update with refresh runs two divides (elapsed split); an
// update with refresh while estimating adds one multiply, one divide by
// progress and two more divides for the remaining split.
// A new item is taken as soon as its predecessor sits in the result
// register, so a stalled receiver holds only that register; the next
// result waits in the sequencer until it is taken.
// After reset the phase is idle, percent and baseline are zero and the wait
// time is one minute.
// ----------------------------------------------------------------------------
module print_time_remaining_estimator import ptre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ptre_req_if.sink   req,
	ptre_rsp_if.source rsp,
	ptre_cfg_if.sink   cfg
);

	logic accept;
	logic seq_ready;
	job_t job;

	assign req.ready = seq_ready;
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && seq_ready;

	ptre_track u_track (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.func            (req.func),
		.percent_done    (req.percent_done),
		.elapsed_seconds (req.elapsed_seconds),
		.heater_temp     (req.heater_temp),
		.heater_target   (req.heater_target),
		.refresh_times   (req.refresh_times),
		.cfg_we          (cfg.valid),
		.cfg_wait        (cfg.wait_minutes),
		.job             (job)
	);

	ptre_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.job    (job),
		.ready  (seq_ready),
		.rsp    (rsp)
	);

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the print time remaining estimator. Directed items
// cover the percent bar extremes, every command and each step of the job
// phases (heating, wait, estimate, saturation, wrap of the wait span).
// Random jobs then run under several wait settings and idle patterns on both
// channels. Each result item is checked field by field against a predictor
// kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top import ptre_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_ROUNDS = 8;
	localparam int ITEMS_PER_ROUND = 140;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		JOB_IDLE,
		JOB_HEATING,
		JOB_WAITING,
		JOB_ESTIMATING
	} job_phase_t;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [PCT_W-1:0]  pct;
		logic [SEC_W-1:0]  elapsed;
		logic [TEMP_W-1:0] temp;
		logic [TEMP_W-1:0] target;
		logic              refresh;
	} cmd_t;

	typedef struct {
		logic              changed;
		logic [PCT_W-1:0]  shown;
		logic [BAR_W-1:0]  bar_lo;
		logic [BAR_W-1:0]  bar_hi;
		logic              tvalid;
		logic [HR_W-1:0]   el_hours;
		logic [MIN_W-1:0]  el_minutes;
		logic              known;
		logic [HR_W-1:0]   rem_hours;
		logic [MIN_W-1:0]  rem_minutes;
	} status_t;

	logic clk = 1'b0;
	logic arst_n;

	ptre_req_if req_ch ();
	ptre_rsp_if rsp_ch ();
	ptre_cfg_if cfg_ch ();

	print_time_remaining_estimator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	job_phase_t        job_phase;
	logic [PCT_W-1:0]  shown_pct;
	logic [SEC_W-1:0]  base_sec;
	logic [PCT_W-1:0]  base_pct;
	logic [WAIT_W-1:0] wait_min;

	status_t pending_status[$];
	int      mismatches;
	int      send_idle_pct;
	int      rcv_stall_pct;
	int      cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top failed");
		$finish;
	end

	always @(negedge clk) begin
		rsp_ch.ready = ($urandom_range(99) >= rcv_stall_pct);
	end

	function automatic void split_secs(input logic [63:0] secs, output logic [HR_W-1:0] hours,
		output logic [MIN_W-1:0] minutes);
		logic [63:0] h;
		h = secs / 64'd3600;
		hours = (h > 64'd65535) ? 16'hffff : h[HR_W-1:0];
		minutes = MIN_W'((secs / 64'd60) % 64'd60);
	endfunction

	function automatic status_t estimate_status(input cmd_t c);
		status_t s;
		logic [PCT_W-1:0] pct;
		logic [SEC_W-1:0] since;
		logic [63:0] dp;
		logic [63:0] de;
		logic [63:0] rem;
		s = '{default: '0};
		pct = (c.pct > PCT_FULL) ? PCT_FULL : c.pct;
		case (c.func)
			FUNC_START: begin
				job_phase = JOB_HEATING;
				s.tvalid = 1'b1;
			end
			FUNC_FINISH: begin
				job_phase = JOB_IDLE;
			end
			FUNC_UPDATE: begin
				if (pct != shown_pct) begin
					shown_pct = pct;
					s.changed = 1'b1;
				end
				if (c.refresh) begin
					s.tvalid = 1'b1;
					split_secs(64'(c.elapsed), s.el_hours, s.el_minutes);
					case (job_phase)
						JOB_HEATING: begin
							if (c.temp >= c.target) begin
								job_phase = JOB_WAITING;
								base_sec = c.elapsed;
								base_pct = pct;
							end
						end
						JOB_WAITING: begin
							since = c.elapsed - base_sec;
							if (since >= 32'(wait_min) * 32'd60)
								job_phase = JOB_ESTIMATING;
						end
						JOB_ESTIMATING: begin
							dp = (pct > base_pct) ? 64'(pct - base_pct) : 64'd0;
							de = (c.elapsed > base_sec) ? 64'(c.elapsed - base_sec) : 64'd0;
							rem = (dp != 0) ? de * (64'd100 - dp) / dp : 64'd0;
							s.known = 1'b1;
							split_secs(rem, s.rem_hours, s.rem_minutes);
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		s.shown = shown_pct;
		s.bar_lo = (shown_pct <= PCT_HALF) ? BAR_W'(shown_pct / 5) : BAR_FULL;
		s.bar_hi = (shown_pct > PCT_HALF) ? BAR_W'((shown_pct - PCT_HALF) / 5) : '0;
		return s;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		status_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_status.size() == 0) begin
				$error("result item with no expectation waiting");
				mismatches++;
			end else begin
				want = pending_status.pop_front();
				check_field("progress_changed", 32'(want.changed),
					32'(rsp_ch.progress_changed));
				check_field("percent_shown", 32'(want.shown), 32'(rsp_ch.percent_shown));
				check_field("bar_first_half", 32'(want.bar_lo),
					32'(rsp_ch.bar_first_half));
				check_field("bar_second_half", 32'(want.bar_hi),
					32'(rsp_ch.bar_second_half));
				check_field("times_valid", 32'(want.tvalid), 32'(rsp_ch.times_valid));
				check_field("elapsed_hours", 32'(want.el_hours),
					32'(rsp_ch.elapsed_hours));
				check_field("elapsed_minutes", 32'(want.el_minutes),
					32'(rsp_ch.elapsed_minutes));
				check_field("remaining_known", 32'(want.known),
					32'(rsp_ch.remaining_known));
				check_field("remaining_hours", 32'(want.rem_hours),
					32'(rsp_ch.remaining_hours));
				check_field("remaining_minutes", 32'(want.rem_minutes),
					32'(rsp_ch.remaining_minutes));
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_cmd(input cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.func = c.func;
		req_ch.percent_done = c.pct;
		req_ch.elapsed_seconds = c.elapsed;
		req_ch.heater_temp = c.temp;
		req_ch.heater_target = c.target;
		req_ch.refresh_times = c.refresh;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		pending_status.push_back(estimate_status(c));
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [FUNC_W-1:0] func, input logic [PCT_W-1:0] pct,
		input logic [SEC_W-1:0] elapsed, input logic [TEMP_W-1:0] temp,
		input logic [TEMP_W-1:0] target, input logic refresh);
		cmd_t c;
		c.func = func;
		c.pct = pct;
		c.elapsed = elapsed;
		c.temp = temp;
		c.target = target;
		c.refresh = refresh;
		send_cmd(c);
	endtask

	function automatic cmd_t random_cmd(input logic [FUNC_W-1:0] func);
		cmd_t c;
		c.func = func;
		c.pct = PCT_W'($urandom_range(127));
		c.elapsed = $urandom;
		c.temp = TEMP_W'($urandom_range(511));
		c.target = TEMP_W'($urandom_range(511));
		c.refresh = 1'($urandom_range(1));
		return c;
	endfunction

	task automatic drain;
		req_ch.valid = 1'b0;
		while (pending_status.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_wait(input logic [WAIT_W-1:0] minutes);
		drain();
		cfg_ch.wait_minutes = minutes;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		wait_min = minutes;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			1: begin
				send_idle_pct = 57;
				rcv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				rcv_stall_pct = 57;
			end
			3: begin
				send_idle_pct = 11;
				rcv_stall_pct = 11;
			end
			default: begin
				send_idle_pct = 0;
				rcv_stall_pct = 0;
			end
		endcase
	endtask

	task automatic test_progress_bars;
		set_idling(0);
		send_fields(FUNC_UPDATE, 7'd0, 32'd0, 9'd0, 9'd0, 1'b0);
		send_fields(FUNC_UPDATE, 7'd50, 32'd0, 9'd0, 9'd0, 1'b0);
		send_fields(FUNC_UPDATE, 7'd51, 32'd0, 9'd0, 9'd0, 1'b0);
		send_fields(FUNC_UPDATE, 7'd100, 32'd0, 9'd0, 9'd0, 1'b0);
		send_fields(FUNC_UPDATE, 7'd101, 32'd0, 9'd0, 9'd0, 1'b0);
		send_fields(FUNC_UPDATE, 7'd127, 32'd0, 9'd0, 9'd0, 1'b0);
		send_cmd(random_cmd(FUNC_UNUSED));
	endtask

	task automatic test_job_phases;
		set_idling(0);
		write_wait(8'd2);
		// idle refresh with saturated elapsed hours
		send_fields(FUNC_UPDATE, 7'd0, 32'hffffffff, 9'd0, 9'd0, 1'b1);
		send_fields(FUNC_START, 7'd5, 32'h12345678, 9'h1ff, 9'h1ff, 1'b1);
		send_fields(FUNC_UPDATE, 7'd5, 32'd500, 9'd100, 9'd200, 1'b1);
		send_fields(FUNC_UPDATE, 7'd10, 32'd1000, 9'd200, 9'd200, 1'b1);
		send_fields(FUNC_UPDATE, 7'd10, 32'd1119, 9'd200, 9'd200, 1'b1);
		send_fields(FUNC_UPDATE, 7'd10, 32'd1120, 9'd200, 9'd200, 1'b1);
		send_fields(FUNC_UPDATE, 7'd10, 32'd2000, 9'd200, 9'd200, 1'b1);
		send_fields(FUNC_UPDATE, 7'd30, 32'd4600, 9'd200, 9'd200, 1'b1);
		send_fields(FUNC_UPDATE, 7'd11, 32'd900, 9'd200, 9'd200, 1'b1);
		send_fields(FUNC_UPDATE, 7'd11, 32'hffffffff, 9'd200, 9'd200, 1'b1);
		send_fields(FUNC_UPDATE, 7'd40, 32'd7000, 9'd200, 9'd200, 1'b0);
		send_fields(FUNC_FINISH, 7'd40, 32'd7000, 9'd0, 9'd0, 1'b1);
		// wait span that wraps past zero
		send_fields(FUNC_START, 7'd0, 32'd0, 9'd0, 9'd0, 1'b0);
		send_fields(FUNC_UPDATE, 7'd20, 32'hffffff00, 9'h1ff, 9'd0, 1'b1);
		send_fields(FUNC_UPDATE, 7'd25, 32'd5, 9'h1ff, 9'd0, 1'b1);
		send_cmd(random_cmd(FUNC_UNUSED));
		send_fields(FUNC_UPDATE, 7'd120, 32'd100, 9'h1ff, 9'd0, 1'b1);
		send_fields(FUNC_FINISH, 7'd0, 32'd0, 9'd0, 9'd0, 1'b0);
	endtask

	task automatic run_jobs(input int n);
		cmd_t c;
		int sent;
		int len;
		int r;
		logic [PCT_W-1:0] pct;
		logic [SEC_W-1:0] sec;
		logic [TEMP_W-1:0] temp;
		logic [TEMP_W-1:0] tgt;
		sent = 0;
		while (sent < n) begin
			send_cmd(random_cmd(FUNC_START));
			sent++;
			pct = PCT_W'($urandom_range(30));
			sec = $urandom_range(200);
			tgt = TEMP_W'($urandom_range(511));
			temp = TEMP_W'($urandom_range(511));
			len = $urandom_range(4, 40);
			repeat (len) begin
				r = $urandom_range(99);
				if (r < 8) begin
					c = random_cmd(FUNC_W'($urandom_range(3)));
				end else begin
					if (temp < tgt)
						temp = (tgt - temp > 30) ? temp + TEMP_W'($urandom_range(30)) : tgt;
					r = $urandom_range(99);
					if (r < 3)
						sec = sec + $urandom;
					else if (r < 10)
						sec = sec + $urandom_range(20000);
					else
						sec = sec + $urandom_range(600);
					r = $urandom_range(99);
					if (r < 5)
						pct = PCT_W'($urandom_range(127));
					else if (r < 75 && pct < 120)
						pct = pct + PCT_W'($urandom_range(6));
					c.func = FUNC_UPDATE;
					c.pct = pct;
					c.elapsed = sec;
					c.temp = temp;
					c.target = tgt;
					c.refresh = ($urandom_range(99) < 75);
				end
				send_cmd(c);
				sent++;
			end
			if ($urandom_range(99) < 80) begin
				send_cmd(random_cmd(FUNC_FINISH));
				sent++;
			end
		end
	endtask

	task automatic test_random_jobs;
		logic [WAIT_W-1:0] minutes;
		for (int i = 0; i < RANDOM_ROUNDS; i++) begin
			case (i)
				0: minutes = 8'd0;
				1: minutes = 8'd255;
				2: minutes = WAIT_RESET;
				default: minutes = WAIT_W'($urandom_range(20));
			endcase
			write_wait(minutes);
			set_idling(i % 4);
			run_jobs(ITEMS_PER_ROUND);
		end
	endtask

	initial begin
		mismatches = 0;
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		job_phase = JOB_IDLE;
		shown_pct = '0;
		base_sec = '0;
		base_pct = '0;
		wait_min = WAIT_RESET;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_UPDATE;
		req_ch.percent_done = '0;
		req_ch.elapsed_seconds = '0;
		req_ch.heater_temp = '0;
		req_ch.heater_target = '0;
		req_ch.refresh_times = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.wait_minutes = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_progress_bars();
		test_job_phases();
		test_random_jobs();
		drain();
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

[print_time_remaining_estimator.f]
sv/ptre_pkg.sv
sv/ptre_ifs.sv
sv/ptre_div.sv
sv/ptre_track.sv
sv/ptre_seq.sv
sv/print_time_remaining_estimator.sv
tb/tb_top.sv
